### hdl/etspt_pkg.sv
// ----------------------------------------------------------------------------
// Encoder-tuned strobe period timer package
// Shared transaction types, command codes and register indexes.
// ----------------------------------------------------------------------------
package etspt_pkg;

	localparam int TIMER_WIDTH = 16;

	// Command codes carried by an input transaction.
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SLOW   = 2'd1,
		CMD_SET    = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PULSE   = 3'd0,
		REG_OFFSET  = 3'd1,
		REG_REVERSE = 3'd2,
		REG_COLLECT = 3'd3,
		REG_REPORT  = 3'd4
	} reg_idx_t;

	localparam logic [15:0] SPACING_RESET = 16'h2fff;
	localparam logic [15:0] TOP_RESET     = 16'd12543;
	localparam logic [7:0]  PULSE_RESET   = 8'h01;
	localparam logic [9:0]  OFFSET_RESET  = 10'h1ff;
	localparam logic [7:0]  COLLECT_RESET = 8'd2;
	localparam logic [7:0]  REPORT_RESET  = 8'd28;
	localparam logic [15:0] SPACING_MAX   = 16'hffff;

	typedef struct packed {
		logic [1:0]  command;
		logic [1:0]  encoder_pins;
		logic [15:0] new_length;
	} item_t;

	typedef struct packed {
		logic [15:0] strobe_length;
		logic [15:0] period_top;
		logic        timer_running;
		logic        strobe_pin;
		logic        report;
		logic [15:0] timer_count;
	} result_t;

	// Outcome of a collect point, from the step unit to the top level.
	typedef struct packed {
		logic        fire;
		logic [7:0]  position;
		logic [15:0] spacing;
	} collect_t;

endpackage

### hdl/etspt_collect.sv
// ----------------------------------------------------------------------------
// Encoder-tuned strobe period timer: collect step
// Turns the encoder position into an exponential, saturating spacing step.
// ----------------------------------------------------------------------------
module etspt_collect (
	input  logic [7:0]        position,
	input  logic [15:0]       spacing,
	output etspt_pkg::collect_t step
);

	logic signed [7:0] pos_s;
	logic signed [7:0] q;
	logic [5:0]        aq;
	logic              big;
	logic [16:0]       mag;
	logic [16:0]       up_sum;

	always_comb begin
		pos_s  = signed'(position);
		// Arithmetic shift gives the floored quotient by four.
		q      = pos_s >>> 2;
		aq     = q[7] ? 6'(-q) : 6'(q);
		// Steps of 4<<14 and more always leave the 16-bit range.
		big    = (aq >= 6'd14);
		mag    = 17'd4 << aq[3:0];
		up_sum = {1'b0, spacing} + mag;

		step.fire     = (q != 8'sd0);
		step.position = 8'(pos_s - q);
		if (!q[7]) begin
			if (big || up_sum[16]) begin
				step.spacing = etspt_pkg::SPACING_MAX;
			end else begin
				step.spacing = up_sum[15:0];
			end
		end else begin
			if (big || (mag > {1'b0, spacing})) begin
				step.spacing = 16'd0;
			end else begin
				step.spacing = 16'({1'b0, spacing} - mag);
			end
		end
	end

endmodule

### hdl/encoder_tuned_strobe_period_timer_unit.sv
// ----------------------------------------------------------------------------
// Encoder-tuned strobe period timer
// Quadrature-tuned strobe spacing with a period timer and strobe pulse.
// ----------------------------------------------------------------------------
// Usage: the item channel (item_valid, item_stall, item) carries one command
// per transaction: an encoder pin sample, a slow tick, a direct length set or
// a timer tick. The result channel (result_valid, result_stall, result)
// returns exactly one transaction per item, holding the spacing, period top,
// run flag, strobe pin, report flag and period count after that item.
// The cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes the five
// registers; cfg_ready is always high and writes are meant for an idle block.
// Path: an accepted item waits in the item register, and its result is then
// written to the result register. Throughput: one item per cycle while the
// receiver does not stall, set by the single compute stage between the two.
// Stalls: while the result register holds an untaken transaction and the
// receiver stalls, an item already in the item register waits and item_stall
// rises; otherwise a new item is taken every cycle.
// Reset: arst_n clears both valid flags, loads spacing 12287, top 12543,
// period count 0, timer running, and the register defaults.
// ----------------------------------------------------------------------------
module encoder_tuned_strobe_period_timer_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  etspt_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output etspt_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	// Configuration registers.
	logic [7:0] pulse_q;
	logic [9:0] offset_q;
	logic       reverse_q;
	logic [7:0] collect_ticks_q;
	logic [7:0] report_ticks_q;

	// Block state.
	logic [7:0]  position_q;
	logic [7:0]  collect_cnt_q;
	logic [7:0]  report_cnt_q;
	logic [15:0] spacing_q;
	logic [15:0] top_q;
	logic [15:0] counter_q;
	logic        running_q;

	// Item stage and result register.
	logic              valid_s1;
	etspt_pkg::item_t  item_s1;
	logic              out_valid_q;
	etspt_pkg::result_t out_q;

	// Next-state values.
	logic [7:0]  position_n;
	logic [7:0]  collect_cnt_n;
	logic [7:0]  report_cnt_n;
	logic [15:0] spacing_n;
	logic [15:0] top_n;
	logic [15:0] counter_n;
	logic        running_n;
	logic        report_n;
	logic        do_apply;
	logic [1:0]  phase;
	logic [7:0]  collect_inc;
	logic [7:0]  report_inc;
	logic [17:0] top_sum;

	etspt_pkg::collect_t coll;

	logic out_free;
	logic advance;

	// The result register can take a transaction when it is empty or being
	// drained this cycle; the item stage moves forward only then.
	assign out_free   = !out_valid_q || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign cfg_ready  = 1'b1;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	etspt_collect u_collect (
		.position (position_q),
		.spacing  (spacing_q),
		.step     (coll)
	);

	always_comb begin
		position_n    = position_q;
		collect_cnt_n = collect_cnt_q;
		report_cnt_n  = report_cnt_q;
		spacing_n     = spacing_q;
		top_n         = top_q;
		counter_n     = counter_q;
		running_n     = running_q;
		report_n      = 1'b0;
		do_apply      = 1'b0;
		collect_inc   = collect_cnt_q + 8'd1;
		report_inc    = report_cnt_q + 8'd1;

		// Gray decode: pins 3 and 2 swap their phases, then optional reversal.
		phase = {item_s1.encoder_pins[1], item_s1.encoder_pins[1] ^ item_s1.encoder_pins[0]};
		if (reverse_q) begin
			phase = ~phase;
		end

		case (etspt_pkg::cmd_t'(item_s1.command))
			etspt_pkg::CMD_SAMPLE: begin
				if (2'(position_q + 8'd1) == phase) begin
					position_n = position_q + 8'd1;
				end else if (2'(position_q - 8'd1) == phase) begin
					position_n = position_q - 8'd1;
				end
			end
			etspt_pkg::CMD_SLOW: begin
				if (collect_inc > collect_ticks_q) begin
					collect_cnt_n = 8'd0;
					if (coll.fire) begin
						position_n = coll.position;
						spacing_n  = coll.spacing;
						do_apply   = 1'b1;
					end
				end else begin
					collect_cnt_n = collect_inc;
				end
				if (report_inc > report_ticks_q) begin
					report_cnt_n = 8'd0;
					report_n     = 1'b1;
				end else begin
					report_cnt_n = report_inc;
				end
			end
			etspt_pkg::CMD_SET: begin
				spacing_n = item_s1.new_length;
				do_apply  = 1'b1;
			end
			etspt_pkg::CMD_TICK: begin
				if (running_q) begin
					if (counter_q >= top_q) begin
						counter_n = 16'd0;
					end else begin
						counter_n = counter_q + 16'd1;
					end
				end
			end
			default: begin
			end
		endcase

		// A spacing change reprograms the top, or stops the timer when the
		// top would not fit in the counter.
		top_sum = {2'b00, spacing_n} + {10'd0, pulse_q} + {8'd0, offset_q};
		if (do_apply) begin
			if (top_sum >= 18'((1 << etspt_pkg::TIMER_WIDTH) - 1)) begin
				running_n = 1'b0;
			end else begin
				top_n     = top_sum[15:0];
				running_n = 1'b1;
				if (counter_q >= top_sum[15:0]) begin
					counter_n = 16'd0;
				end
			end
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q         <= etspt_pkg::PULSE_RESET;
			offset_q        <= etspt_pkg::OFFSET_RESET;
			reverse_q       <= 1'b1;
			collect_ticks_q <= etspt_pkg::COLLECT_RESET;
			report_ticks_q  <= etspt_pkg::REPORT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (etspt_pkg::reg_idx_t'(cfg_index))
				etspt_pkg::REG_PULSE:   pulse_q         <= cfg_data[7:0];
				etspt_pkg::REG_OFFSET:  offset_q        <= cfg_data[9:0];
				etspt_pkg::REG_REVERSE: reverse_q       <= cfg_data[0];
				etspt_pkg::REG_COLLECT: collect_ticks_q <= cfg_data[7:0];
				etspt_pkg::REG_REPORT:  report_ticks_q  <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// State update, one item per cycle while the result register can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= 8'd0;
			collect_cnt_q <= 8'd0;
			report_cnt_q  <= 8'd0;
			spacing_q     <= etspt_pkg::SPACING_RESET;
			top_q         <= etspt_pkg::TOP_RESET;
			counter_q     <= 16'd0;
			running_q     <= 1'b1;
		end else if (advance) begin
			position_q    <= position_n;
			collect_cnt_q <= collect_cnt_n;
			report_cnt_q  <= report_cnt_n;
			spacing_q     <= spacing_n;
			top_q         <= top_n;
			counter_q     <= counter_n;
			running_q     <= running_n;
		end
	end

	// Valid flags of the item stage and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
		if (advance) begin
			out_q.strobe_length <= spacing_n;
			out_q.period_top    <= top_n;
			out_q.timer_running <= running_n;
			out_q.strobe_pin    <= (counter_n >= {8'd0, pulse_q});
			out_q.report        <= report_n;
			out_q.timer_count   <= counter_n;
		end
	end

endmodule

### test/tb_encoder_tuned_strobe_period_timer_unit.sv
// ----------------------------------------------------------------------------
// Encoder-tuned strobe period timer testbench
// Sends encoder samples, slow ticks, length sets and timer ticks through the
// item channel under random idling and stalls. Every result transaction is
// checked field by field against a cycle-free predictor of the strobe timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_encoder_tuned_strobe_period_timer_unit;

	import etspt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	// The receiver holds off once, after HOLD_AFTER results, for a hold whose length HOLD_CYCLES sets.
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 150;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic    cfg_valid    = 1'b0;
	logic    cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	encoder_tuned_strobe_period_timer_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Items waiting to be offered, and the results the accepted items must produce.
	item_t   queued_items[$];
	result_t due_results[$];

	int err_count      = 0;
	int items_made     = 0;
	int items_accepted = 0;
	int results_seen   = 0;
	int hold_left      = 0;
	bit hold_done      = 1'b0;

	// For a while in the middle of the run neither side idles, so the block
	// sees back-to-back transactions on both channels.
	wire steady = (items_accepted >= 1000) && (items_accepted < 1300);

	// ------------------------------------------------------------------------
	// Predicted block state and register copies.
	// ------------------------------------------------------------------------
	logic [7:0]  cfg_pulse   = PULSE_RESET;
	logic [9:0]  cfg_offset  = OFFSET_RESET;
	logic        cfg_reverse = 1'b1;
	logic [7:0]  cfg_collect = COLLECT_RESET;
	logic [7:0]  cfg_report  = REPORT_RESET;

	logic [7:0]  enc_pos     = '0;
	logic [7:0]  collect_cnt = '0;
	logic [7:0]  report_cnt  = '0;
	logic [15:0] spacing_q   = SPACING_RESET;
	logic [15:0] top_q       = TOP_RESET;
	logic [15:0] count_q     = '0;
	logic        running_q   = 1'b1;

	// Shadow of the position used while items are generated, so that encoder
	// runs can be steered to move the position in a chosen direction.
	logic [7:0]  gen_pos     = '0;
	logic [7:0]  gen_collect = '0;

	// The pins are Gray coded: pins 3 mean phase 2 and pins 2 mean phase 3.
	// A phase one step away from the low bits of the position moves it by one.
	function automatic logic [7:0] next_position(logic [7:0] p, logic [1:0] pins, logic rev);
		logic [1:0] ph;
		ph = (pins == 2'd3) ? 2'd2 : ((pins == 2'd2) ? 2'd3 : pins);
		if (rev)
			ph = ~ph;
		if (2'(p[1:0] + 2'd1) == ph)
			return p + 8'd1;
		else if (2'(p[1:0] - 2'd1) == ph)
			return p - 8'd1;
		return p;
	endfunction

	// Floor of the signed position divided by four.
	function automatic int position_quarter(logic [7:0] p);
		int v;
		v = int'($signed(p));
		return v >>> 2;
	endfunction

	// Pins that decode to the wanted phase under the current direction setting.
	function automatic logic [1:0] pins_for_phase(logic [1:0] ph, logic rev);
		if (rev)
			ph = ~ph;
		return (ph == 2'd2) ? 2'd3 : ((ph == 2'd3) ? 2'd2 : ph);
	endfunction

	// A spacing change either stops the timer, when the period would not fit
	// the counter, or moves the top and pulls the counter back under it.
	function void reprogram_top();
		int lim;
		lim = (1 << TIMER_WIDTH) - 1 - int'(cfg_offset) - int'(cfg_pulse);
		if (int'(spacing_q) >= lim) begin
			running_q = 1'b0;
		end else begin
			top_q = spacing_q + {8'd0, cfg_pulse} + {6'd0, cfg_offset};
			if (count_q >= top_q)
				count_q = '0;
			running_q = 1'b1;
		end
	endfunction

	// At a collect point a quarter of the position is taken out and turned into
	// an exponential step of the spacing. Steps of 64k and more simply saturate.
	function void apply_collect();
		int q;
		int aq;
		longint mag;
		longint len;
		q = position_quarter(enc_pos);
		if (q == 0)
			return;
		enc_pos = enc_pos - 8'(q);
		aq = (q < 0) ? -q : q;
		if (aq > 16)
			aq = 16;
		mag = longint'(4) << aq;
		len = longint'(spacing_q) + ((q > 0) ? mag : -mag);
		if (len > 65535)
			len = 65535;
		if (len < 0)
			len = 0;
		spacing_q = 16'(len);
		reprogram_top();
	endfunction

	// Advances the predicted state by one item and returns the result it gives.
	function result_t predict_strobe(item_t it);
		result_t r;
		logic rep;
		rep = 1'b0;
		case (cmd_t'(it.command))
			CMD_SAMPLE: begin
				enc_pos = next_position(enc_pos, it.encoder_pins, cfg_reverse);
			end
			CMD_SLOW: begin
				collect_cnt = collect_cnt + 8'd1;
				if (collect_cnt > cfg_collect) begin
					collect_cnt = '0;
					apply_collect();
				end
				report_cnt = report_cnt + 8'd1;
				if (report_cnt > cfg_report) begin
					report_cnt = '0;
					rep = 1'b1;
				end
			end
			CMD_SET: begin
				spacing_q = it.new_length;
				reprogram_top();
			end
			default: begin
				if (running_q)
					count_q = (count_q >= top_q) ? 16'd0 : count_q + 16'd1;
			end
		endcase
		r.strobe_length = spacing_q;
		r.period_top    = top_q;
		r.timer_running = running_q;
		r.strobe_pin    = (count_q < {8'd0, cfg_pulse}) ? 1'b0 : 1'b1;
		r.report        = rep;
		r.timer_count   = count_q;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Item driver: offers the queued items, holding each one steady while the
	// block stalls, and predicts the result of every accepted transaction.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : item_driver
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				due_results.push_back(predict_strobe(item));
				items_accepted <= items_accepted + 1;
			end
			// A new item is only picked once the current one has been taken, so
			// valid and payload never change under a stall.
			if (!item_valid || !item_stall) begin
				if (queued_items.size() != 0 && (steady || $urandom_range(0, 99) >= 15)) begin
					item       <= queued_items.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Result monitor: compares each accepted result with the oldest prediction
	// and drives the receiver stall, including one long hold-off that lets the
	// block fill up and stall its item channel.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				if (due_results.size() == 0) begin
					$error("result transaction with no item waiting for it");
					err_count++;
				end else begin
					want = due_results.pop_front();
					check_field("strobe_length", want.strobe_length, result.strobe_length);
					check_field("period_top", want.period_top, result.period_top);
					check_field("timer_running", {15'd0, want.timer_running},
						{15'd0, result.timer_running});
					check_field("strobe_pin", {15'd0, want.strobe_pin},
						{15'd0, result.strobe_pin});
					check_field("report", {15'd0, want.report}, {15'd0, result.report});
					check_field("timer_count", want.timer_count, result.timer_count);
				end
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
				result_stall <= 1'b1;
			end else begin
				result_stall <= !steady && ($urandom_range(0, 99) < 15);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus generation.
	// ------------------------------------------------------------------------
	// Queues one item and keeps the position shadow in step with it.
	task automatic queue_item(cmd_t cmd, logic [1:0] pins, logic [15:0] len);
		item_t it;
		int q;
		it.command      = cmd;
		it.encoder_pins = pins;
		it.new_length   = len;
		queued_items.push_back(it);
		items_made++;
		if (cmd == CMD_SAMPLE) begin
			gen_pos = next_position(gen_pos, pins, cfg_reverse);
		end else if (cmd == CMD_SLOW) begin
			gen_collect = gen_collect + 8'd1;
			if (gen_collect > cfg_collect) begin
				gen_collect = '0;
				q = position_quarter(gen_pos);
				gen_pos = gen_pos - 8'(q);
			end
		end
	endtask

	// Turns the encoder a number of steps one way; with some noise a sample
	// carries random pins instead, which may step, stand still or reverse.
	task automatic turn_encoder(int dir, int steps, int noise_pct);
		logic [1:0] pins;
		for (int i = 0; i < steps; i++) begin
			if ($urandom_range(0, 99) < noise_pct)
				pins = 2'($urandom);
			else
				pins = pins_for_phase(2'(gen_pos[1:0] + dir), cfg_reverse);
			queue_item(CMD_SAMPLE, pins, 16'($urandom));
		end
	endtask

	// Lengths cluster around the stop limit, the ends of the range and small
	// values that give short periods, so the counter wraps often.
	function automatic logic [15:0] pick_length();
		int lim;
		int v;
		lim = 65535 - int'(cfg_offset) - int'(cfg_pulse);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom_range(0, 64);
			4, 5:       v = $urandom_range(0, 65535);
			6, 7:       v = lim - 2 + $urandom_range(0, 3);
			8:          v = $urandom_range(0, 1) ? 65535 : 0;
			default:    v = $urandom_range(lim / 2, 65535);
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return 16'(v);
	endfunction

	// Waits until every queued item has been taken and every result checked.
	// The block has no work left then, so registers may be written.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (queued_items.size() != 0 || item_valid || due_results.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PULSE:   cfg_pulse   = val[7:0];
			REG_OFFSET:  cfg_offset  = val[9:0];
			REG_REVERSE: cfg_reverse = val[0];
			REG_COLLECT: cfg_collect = val[7:0];
			REG_REPORT:  cfg_report  = val[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	// One phase: drain, write all five registers, then a random mix of encoder
	// runs, slow ticks, length sets and bursts of timer ticks.
	task automatic run_phase(int pulse, int offset, int rev, int collect, int rpt, int n);
		int target;
		int k;
		wait_idle();
		write_reg(REG_PULSE, 16'(pulse));
		write_reg(REG_OFFSET, 16'(offset));
		write_reg(REG_REVERSE, 16'(rev));
		write_reg(REG_COLLECT, 16'(collect));
		write_reg(REG_REPORT, 16'(rpt));
		gen_pos     = enc_pos;
		gen_collect = collect_cnt;
		target      = items_made + n;
		while (items_made < target) begin
			k = $urandom_range(0, 99);
			if (k < 40) begin
				// Mostly short turns; now and then a long one that builds a large
				// position and hence a saturating step at the next collect point.
				turn_encoder($urandom_range(0, 1) ? 1 : -1,
					($urandom_range(0, 7) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 10),
					10);
			end else if (k < 62) begin
				repeat ($urandom_range(1, 4))
					queue_item(CMD_SLOW, 2'($urandom), 16'($urandom));
			end else if (k < 75) begin
				queue_item(CMD_SET, 2'($urandom), pick_length());
			end else begin
				repeat ($urandom_range(1, 24))
					queue_item(CMD_TICK, 2'($urandom), 16'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : main_sequence
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items under the reset settings: all pin values, a forward
		// turn collected into a step, a stop at full length, a tick while
		// stopped, both sides of the stop limit and alternating length bits.
		queue_item(CMD_TICK, 2'd0, 16'd0);
		queue_item(CMD_SAMPLE, 2'd0, 16'd0);
		queue_item(CMD_SAMPLE, 2'd1, 16'd0);
		queue_item(CMD_SAMPLE, 2'd2, 16'd0);
		queue_item(CMD_SAMPLE, 2'd3, 16'd0);
		turn_encoder(1, 5, 0);
		repeat (3)
			queue_item(CMD_SLOW, 2'd0, 16'd0);
		queue_item(CMD_SET, 2'd0, 16'd0);
		queue_item(CMD_SET, 2'd0, 16'hffff);
		queue_item(CMD_TICK, 2'd0, 16'd0);
		queue_item(CMD_SET, 2'd0, 16'd65023);
		queue_item(CMD_SET, 2'd0, 16'd65022);
		queue_item(CMD_TICK, 2'd0, 16'd0);
		queue_item(CMD_SET, 2'd0, 16'h5555);
		queue_item(CMD_SET, 2'd0, 16'haaaa);

		// Lowest settings: collect and report on every slow tick.
		run_phase(0, 0, 0, 0, 0, 300);
		// Highest settings: collect and report can never fire.
		run_phase(255, 1023, 1, 255, 255, 300);
		run_phase($urandom_range(0, 8), $urandom_range(0, 40), $urandom_range(0, 1),
			$urandom_range(1, 6), $urandom_range(0, 30), 300);
		run_phase($urandom_range(0, 255), $urandom_range(0, 1023), $urandom_range(0, 1),
			$urandom_range(0, 15), $urandom_range(0, 255), 300);
		run_phase(1, 1, 0, 3, 5, 300);
		run_phase($urandom_range(200, 255), $urandom_range(0, 1023), 1, 0, 1, 300);

		wait_idle();
		repeat (8) @(posedge clk);
		if (err_count == 0 && due_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

endmodule
